FILE: design/spq_pkg.sv
// shared types and constants for the sorted priority queue
package spq_pkg;

  localparam int unsigned SPQ_DEPTH = 16;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned OccW      = 5;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [OccW-1:0]          occ_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // update request from the control stage to the entry row
  typedef struct packed {
    logic ins;
    logic rem;
  } spq_cmd_t;

endpackage

FILE: design/spq_if.sv
// request and response channel interfaces of the sorted priority queue
interface spq_req_if import spq_pkg::*; ();
  logic    valid;
  logic    ready;
  action_e action;
  value_t  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
  logic    valid;
  logic    ready;
  status_e status;
  value_t  removed_value;
  occ_t    occupancy;

  modport source (output valid, output status, output removed_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input occupancy,
                  output ready);
endinterface

FILE: design/spq_entry_row.sv
// row of sorted entry cells with parallel compare and shift
module spq_entry_row import spq_pkg::*; #(
  parameter int unsigned DEPTH = SPQ_DEPTH,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spq_cmd_t        cmd_i,
  input  value_t          value_i,
  output value_t          head_o,
  output logic [CntW-1:0] count_next_o,
  output logic            full_o,
  output logic            empty_o
);

  value_t          entries_q [DEPTH];
  value_t          entries_d [DEPTH];
  logic [DEPTH-1:0] lt;
  logic [CntW-1:0] count_q, count_d;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t ins_val;
    value_t rem_val;

    // occupied and strictly smaller than the new value: stays in place
    assign lt[i] = (CntW'(i) < count_q) && (entries_q[i] < value_i);

    if (i == 0) begin : g_first
      assign ins_val = lt[i] ? entries_q[i] : value_i;
    end else begin : g_rest
      always_comb begin
        if (lt[i]) begin
          ins_val = entries_q[i];
        end else if (lt[i-1]) begin
          ins_val = value_i;
        end else begin
          ins_val = entries_q[i-1];
        end
      end
    end

    if (i == DEPTH - 1) begin : g_last
      assign rem_val = entries_q[i];
    end else begin : g_mid
      assign rem_val = entries_q[i+1];
    end

    assign entries_d[i] = cmd_i.ins ? ins_val : rem_val;

    always_ff @(posedge clk_i) begin
      if (cmd_i.ins || cmd_i.rem) begin
        entries_q[i] <= entries_d[i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_o       = entries_q[0];
  assign count_next_o = count_d;
  assign full_o       = (count_q == CntW'(DEPTH));
  assign empty_o      = (count_q == '0);

endmodule

FILE: design/sorted_priority_queue_unit.sv
// Sorted priority queue: keeps up to DEPTH signed values in ascending order.
// Request channel (req_i): action insert places value before the first stored
// value that is not smaller; action remove takes out the smallest value.
// Response channel (rsp_o): one beat per request with status, the removed
// value (zero unless a remove succeeded) and the occupancy after the request.
// An insert into a full store is dropped with status full; a remove from an
// empty store changes nothing and reports status empty.
// Timing: a request beat is captured in an input register; once the
// response register is free or being taken, one pass of parallel compares
// over all entries, plus a one-place shift of the entry row, updates the
// store and loads the response register. Response valid is registered from
// the input register's valid flag; one request per cycle is sustained while
// the receiver takes responses, set by the single compare-and-shift pass.
// Reset empties the store (occupancy zero) and clears both valid flags.
// When the receiver stalls, the response holds and the input register keeps
// one pending request; request ready drops until the response is taken.
module sorted_priority_queue_unit import spq_pkg::*; #(
  parameter int unsigned DEPTH = SPQ_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  spq_req_if.sink       req_i,
  spq_rsp_if.source     rsp_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic            req_vld_q;
  action_e         req_act_q;
  value_t          req_val_q;
  logic            rsp_vld_q;
  status_e         rsp_status_q, rsp_status_d;
  value_t          rsp_value_q, rsp_value_d;
  occ_t            rsp_occ_q;
  logic            advance, fire, req_take;
  spq_cmd_t        cmd;
  value_t          head;
  logic [CntW-1:0] count_next;
  logic            full, empty;

  assign advance     = !rsp_vld_q || rsp_o.ready;
  assign fire        = req_vld_q && advance;
  assign req_i.ready = !req_vld_q || advance;
  assign req_take    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (req_take) begin
      req_vld_q <= 1'b1;
    end else if (fire) begin
      req_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      req_act_q <= req_i.action;
      req_val_q <= req_i.value;
    end
  end

  always_comb begin
    cmd.ins = fire && (req_act_q == ACT_INSERT) && !full;
    cmd.rem = fire && (req_act_q == ACT_REMOVE) && !empty;
  end

  spq_entry_row #(
    .DEPTH (DEPTH)
  ) u_row (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (req_val_q),
    .head_o       (head),
    .count_next_o (count_next),
    .full_o       (full),
    .empty_o      (empty)
  );

  always_comb begin
    rsp_status_d = ST_DONE;
    rsp_value_d  = '0;
    case (req_act_q)
      ACT_INSERT: begin
        if (full) begin
          rsp_status_d = ST_FULL;
        end
      end
      ACT_REMOVE: begin
        if (empty) begin
          rsp_status_d = ST_EMPTY;
        end else begin
          rsp_value_d = head;
        end
      end
      default: rsp_status_d = ST_DONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (advance) begin
      rsp_vld_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_status_q <= rsp_status_d;
      rsp_value_q  <= rsp_value_d;
      rsp_occ_q    <= OccW'(count_next);
    end
  end

  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.removed_value = rsp_value_q;
  assign rsp_o.occupancy     = rsp_occ_q;

endmodule
